@@ rtl/core/errp_pkg.sv @@
package errp_pkg;

  // Fixed field widths of the request and response items
  localparam int unsigned SVC_W     = 4;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned MASK_BITS = 16;
  localparam int unsigned IDX_W     = 4;

  // Parameter defaults
  localparam int unsigned MAX_INSTANCES_DEF = 16;
  localparam int unsigned NUM_SERVICES_DEF  = 16;
  localparam int unsigned TICKET_WIDTH_DEF  = 32;

endpackage

@@ rtl/core/errp_if.sv @@
interface errp_req_if
  import errp_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [SVC_W-1:0]     service_id;
  logic [COUNT_W-1:0]   instance_count;
  logic [MASK_BITS-1:0] healthy_mask;
  logic [MASK_BITS-1:0] blocked_mask;
  logic [MASK_BITS-1:0] exclude_mask;

  modport source (output valid, service_id, instance_count, healthy_mask,
                  blocked_mask, exclude_mask, input ready);
  modport sink   (input valid, service_id, instance_count, healthy_mask,
                  blocked_mask, exclude_mask, output ready);
endinterface

interface errp_rsp_if
  import errp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             found;
  logic [IDX_W-1:0] chosen_index;

  modport source (output valid, found, chosen_index, input ready);
  modport sink   (input valid, found, chosen_index, output ready);
endinterface

@@ rtl/core/eligible_round_robin_picker_core.sv @@
// Sequence: a request is taken only while idle; the serial remainder unit then
//   handles one ticket bit per cycle, and a pick step registers the response.
// No new request is taken until the pick step has stored its response; a request
//   with nothing eligible or an out-of-range service skips the remainder loop.
// Reset: rst_ni asynchronous, active low; clears all ticket counters, the
//   sequencer and the response valid flag.
module eligible_round_robin_picker_core
  import errp_pkg::*;
#(
  parameter int unsigned MAX_INSTANCES = MAX_INSTANCES_DEF,
  parameter int unsigned NUM_SERVICES  = NUM_SERVICES_DEF,
  parameter int unsigned TICKET_WIDTH  = TICKET_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  errp_req_if.sink    req_i,
  errp_rsp_if.source  rsp_o
);

  // Only 16 services are reachable through the 4-bit service id.
  localparam int unsigned SVC_SPAN  = 1 << SVC_W;
  localparam int unsigned CNT_DEPTH = (NUM_SERVICES < SVC_SPAN) ? NUM_SERVICES : SVC_SPAN;
  localparam int unsigned CNT_IW    = (CNT_DEPTH > 1) ? $clog2(CNT_DEPTH) : 1;
  // Instance count saturates at the smaller of MAX_INSTANCES and the mask width.
  localparam int unsigned INST_LIM  = (MAX_INSTANCES < MASK_BITS) ? MAX_INSTANCES : MASK_BITS;
  localparam int unsigned BIT_W     = (TICKET_WIDTH > 1) ? $clog2(TICKET_WIDTH) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PICK
  } state_e;

  function automatic logic [COUNT_W-1:0] popcount(input logic [MASK_BITS-1:0] v);
    logic [COUNT_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < MASK_BITS; k++) begin
      acc = acc + COUNT_W'(v[k]);
    end
    return acc;
  endfunction

  state_e                  state_q;
  logic [MASK_BITS-1:0]    elig_q;
  logic [COUNT_W-1:0]      n_elig_q;
  logic [IDX_W-1:0]        rem_q;
  logic [TICKET_WIDTH-1:0] tkt_q;
  logic [BIT_W-1:0]        bit_cnt_q;
  logic                    hit_q;      // the service is in range and an eligible instance exists for this request
  logic                    out_valid_q;
  logic                    out_found_q;
  logic [IDX_W-1:0]        out_idx_q;

  // Per-service ticket counters, small enough to stay in flops with reset.
  logic [TICKET_WIDTH-1:0] tickets_q [CNT_DEPTH];

  // ---------------------------------------------------------------------
  // Request decode: eligibility mask and its population, done at transfer
  // ---------------------------------------------------------------------
  logic                 req_xfer;
  logic                 svc_in_range;
  logic [COUNT_W-1:0]   count_lim;
  logic [MASK_BITS-1:0] range_mask;
  logic [MASK_BITS-1:0] elig_in;
  logic [COUNT_W-1:0]   n_elig_in;
  logic                 hit_in;
  logic [CNT_IW-1:0]    svc_idx;

  assign req_i.ready  = (state_q == ST_IDLE);
  assign req_xfer     = req_i.valid && req_i.ready;
  assign svc_in_range = (32'(req_i.service_id) < NUM_SERVICES);
  assign svc_idx      = CNT_IW'(req_i.service_id);

  always_comb begin
    if (32'(req_i.instance_count) > INST_LIM) begin
      count_lim = COUNT_W'(INST_LIM);
    end else begin
      count_lim = req_i.instance_count;
    end
    for (int k = 0; k < MASK_BITS; k++) begin
      range_mask[k] = (COUNT_W'(k) < count_lim);
    end
  end

  assign elig_in   = req_i.healthy_mask & ~req_i.blocked_mask & ~req_i.exclude_mask
                     & range_mask;
  assign n_elig_in = popcount(elig_in);
  assign hit_in    = svc_in_range && (n_elig_in != '0);

  // ---------------------------------------------------------------------
  // Shared restoring remainder step: one ticket bit per cycle, MSB first
  // ---------------------------------------------------------------------
  logic [IDX_W:0]   shifted;
  logic [IDX_W:0]   diff;
  logic [IDX_W-1:0] rem_next;

  assign shifted  = {rem_q, tkt_q[TICKET_WIDTH-1]};
  assign diff     = shifted - n_elig_q;
  assign rem_next = (shifted >= n_elig_q) ? diff[IDX_W-1:0] : shifted[IDX_W-1:0];

  // ---------------------------------------------------------------------
  // Pick: the eligible instance whose count of eligible instances below it
  // equals the remainder
  // ---------------------------------------------------------------------
  logic [IDX_W-1:0] pick_idx;

  always_comb begin
    logic [COUNT_W-1:0] below;
    pick_idx = '0;
    for (int i = 0; i < MASK_BITS; i++) begin
      below = '0;
      for (int j = 0; j < i; j++) begin
        below = below + COUNT_W'(elig_q[j]);
      end
      if (elig_q[i] && (below == COUNT_W'(rem_q))) begin
        pick_idx = pick_idx | IDX_W'(i);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer and response register
  // ---------------------------------------------------------------------
  logic out_free;
  assign out_free = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // A new response takes the slot; otherwise a transfer empties it.
      if ((state_q == ST_PICK) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (req_xfer) begin
            elig_q    <= elig_in;
            n_elig_q  <= n_elig_in;
            hit_q     <= hit_in;
            tkt_q     <= tickets_q[svc_idx];
            rem_q     <= '0;
            bit_cnt_q <= BIT_W'(TICKET_WIDTH - 1);
            state_q   <= hit_in ? ST_DIV : ST_PICK;
          end
        end
        ST_DIV: begin
          rem_q     <= rem_next;
          tkt_q     <= tkt_q << 1;
          bit_cnt_q <= bit_cnt_q - 1'b1;
          if (bit_cnt_q == '0) begin
            state_q <= ST_PICK;
          end
        end
        ST_PICK: begin
          // Hold here while the previous response still waits.
          if (out_free) begin
            out_found_q <= hit_q;
            out_idx_q   <= hit_q ? pick_idx : '0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Ticket read happens at transfer; for a hit the increment is stored the same edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < CNT_DEPTH; s++) begin
        tickets_q[s] <= '0;
      end
    end else if (req_xfer && hit_in) begin
      tickets_q[svc_idx] <= tickets_q[svc_idx] + 1'b1;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.found        = out_found_q;
  assign rsp_o.chosen_index = out_idx_q;

endmodule

@@ tb/tb_eligible_round_robin_picker_core.sv @@
`timescale 1ns / 100ps

module tb_eligible_round_robin_picker_core;
  import errp_pkg::*;

  // Run shape
  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned HOLD_CYCLES  = 400;  // long response back-pressure stretch
  localparam int unsigned HOLD_AFTER   = 60;   // request transfers before the stretch
  localparam int unsigned DRAIN_CYCLES = TICKET_WIDTH_DEF + 2 + 16;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [SVC_W-1:0]     service_id;
    logic [COUNT_W-1:0]   instance_count;
    logic [MASK_BITS-1:0] healthy;
    logic [MASK_BITS-1:0] blocked;
    logic [MASK_BITS-1:0] exclude;
  } request_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] index;
  } pick_t;

  // Predicts each pick from its own copy of the per-service ticket counters
  // and checks responses in order against the picks still owed.
  class pick_checker;
    logic [TICKET_WIDTH_DEF-1:0] ticket_ctr[NUM_SERVICES_DEF];
    pick_t                       picks_due[$];
    int unsigned                 errors;

    function new();
      foreach (ticket_ctr[s]) ticket_ctr[s] = '0;
      errors = 0;
    endfunction

    task report(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    function void log_request(input request_t r);
      int unsigned                 lim;
      int unsigned                 cnt;
      int unsigned                 n_elig;
      int unsigned                 rem;
      logic [MASK_BITS-1:0]        elig;
      logic [TICKET_WIDTH_DEF-1:0] ticket;
      pick_t                       p;
      lim = (MAX_INSTANCES_DEF < MASK_BITS) ? MAX_INSTANCES_DEF : MASK_BITS;
      cnt = (r.instance_count < lim) ? r.instance_count : lim;
      elig = r.healthy & ~r.blocked & ~r.exclude;
      for (int i = 0; i < MASK_BITS; i++)
        if (i >= cnt) elig[i] = 1'b0;
      n_elig = $countones(elig);
      p = '0;
      if (r.service_id < NUM_SERVICES_DEF && n_elig != 0) begin
        ticket = ticket_ctr[r.service_id];
        ticket_ctr[r.service_id] = ticket + 1'b1;  // wraps at counter width
        rem = ticket % n_elig;
        for (int i = 0; i < MASK_BITS; i++) begin
          if (elig[i] && !p.found) begin
            if (rem == 0) begin
              p.found = 1'b1;
              p.index = IDX_W'(i);
            end else begin
              rem--;
            end
          end
        end
      end
      picks_due.push_back(p);
    endfunction

    task check_pick(input logic found, input logic [IDX_W-1:0] index);
      pick_t want;
      if (picks_due.size() == 0) begin
        report($sformatf("response found=%0b index=%0d with no request outstanding",
                         found, index));
        return;
      end
      want = picks_due.pop_front();
      if (found !== want.found)
        report($sformatf("found got %0b want %0b", found, want.found));
      if (index !== want.index)
        report($sformatf("chosen_index got %0d want %0d", index, want.index));
    endtask

    function int unsigned pending();
      return picks_due.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  errp_req_if req_if ();
  errp_rsp_if rsp_if ();

  eligible_round_robin_picker_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  pick_checker picks = new();

  int unsigned req_transfers = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned snd_idle_pct  = 0;
  int unsigned rsp_idle_pct  = 0;
  bit          hold_rsp      = 1'b0;

  // 12 ns period
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Watchdog: a correct run finishes far below this
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Response side: ready is changed only at falling edges. hold_rsp forces a
  // long stall so the block fills and back-pressures the request side.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_if.ready <= !hold_rsp && ($urandom_range(0, 99) >= rsp_idle_pct);
    end
  end

  // Long hold-off, counted here so the request driver keeps offering meanwhile
  initial begin
    wait (req_transfers >= HOLD_AFTER);
    @(posedge clk_i);
    hold_rsp = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rsp = 1'b0;
  end

  // Response monitor: a transfer is valid && ready at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      picks.check_pick(rsp_if.found, rsp_if.chosen_index);
  end

  function automatic request_t mk_req(input int unsigned svc, input int unsigned cnt,
                                      input int unsigned h, input int unsigned b,
                                      input int unsigned x);
    request_t r;
    r.service_id     = SVC_W'(svc);
    r.instance_count = COUNT_W'(cnt);
    r.healthy        = MASK_BITS'(h);
    r.blocked        = MASK_BITS'(b);
    r.exclude        = MASK_BITS'(x);
    return r;
  endfunction

  // Mostly plausible traffic: a few hot services so tickets climb, dense health,
  // sparse breaker and exclude masks so most requests find something. The rest
  // is fully random noise that covers every field bit and oversize counts.
  function automatic request_t random_request();
    request_t r;
    if ($urandom_range(0, 99) < 80) begin
      r.service_id     = ($urandom_range(0, 3) == 0) ? SVC_W'($urandom_range(0, 15))
                                                     : SVC_W'($urandom_range(0, 3));
      r.instance_count = COUNT_W'($urandom_range(1, 16));
      r.healthy        = MASK_BITS'($urandom | $urandom);
      r.blocked        = MASK_BITS'($urandom & $urandom & $urandom);
      r.exclude        = MASK_BITS'($urandom & $urandom);
    end else begin
      r.service_id     = SVC_W'($urandom);
      r.instance_count = COUNT_W'($urandom_range(0, 31));
      r.healthy        = MASK_BITS'($urandom);
      r.blocked        = MASK_BITS'($urandom);
      r.exclude        = MASK_BITS'($urandom);
    end
    return r;
  endfunction

  // One request transfer. Starts at a falling edge; optional idle gap with
  // valid low, then valid stays high until ready is seen at a rising edge.
  task automatic send_request(input request_t r);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.service_id     <= r.service_id;
    req_if.instance_count <= r.instance_count;
    req_if.healthy_mask   <= r.healthy;
    req_if.blocked_mask   <= r.blocked;
    req_if.exclude_mask   <= r.exclude;
    do @(posedge clk_i); while (!req_if.ready);
    picks.log_request(r);
    req_transfers++;
  endtask

  initial begin
    request_t    directed[$];
    int unsigned total;
    int unsigned phase_a_end;
    int unsigned phase_b_end;

    req_if.valid          = 1'b0;
    req_if.service_id     = '0;
    req_if.instance_count = '0;
    req_if.healthy_mask   = '0;
    req_if.blocked_mask   = '0;
    req_if.exclude_mask   = '0;
    rst_ni                = 1'b0;

    // Directed: field extremes, count saturation, empty eligibility, single
    // survivors at the top bit, and repeat hits on one service to step tickets.
    directed.push_back(mk_req(0,  0, 'hFFFF, 'h0000, 'h0000)); // zero instances
    directed.push_back(mk_req(0, 16, 'hFFFF, 'h0000, 'h0000));
    directed.push_back(mk_req(0, 16, 'hFFFF, 'h0000, 'h0000));
    directed.push_back(mk_req(0, 16, 'hFFFF, 'h0000, 'h0000));
    directed.push_back(mk_req(1, 31, 'hFFFF, 'h0000, 'h0000)); // count saturates
    directed.push_back(mk_req(1, 17, 'hFFFF, 'h0000, 'h0000));
    directed.push_back(mk_req(1, 31, 'h8000, 'h0000, 'h0000)); // only bit 15, oversize
    directed.push_back(mk_req(2, 16, 'h0000, 'h0000, 'h0000)); // nothing healthy
    directed.push_back(mk_req(2, 16, 'hFFFF, 'hFFFF, 'h0000)); // all blocked
    directed.push_back(mk_req(2, 16, 'hFFFF, 'h0000, 'hFFFF)); // all excluded
    directed.push_back(mk_req(2, 16, 'h8000, 'h0000, 'h0000)); // top instance only
    directed.push_back(mk_req(2, 15, 'h8000, 'h0000, 'h0000)); // top beyond count
    directed.push_back(mk_req(15, 16, 'hAAAA, 'h0000, 'h0000));
    directed.push_back(mk_req(15, 16, 'hAAAA, 'h0000, 'h0000));
    directed.push_back(mk_req(15, 16, 'h5555, 'h0000, 'h0000));
    directed.push_back(mk_req(15, 16, 'hFFFF, 'h00FF, 'h0F00)); // upper nibble left
    directed.push_back(mk_req(15, 16, 'hFFFF, 'h00FF, 'h0F00));
    directed.push_back(mk_req(3,  1, 'h0001, 'h0000, 'h0000));
    directed.push_back(mk_req(3,  1, 'hFFFE, 'h0000, 'h0000)); // bit 0 unhealthy
    directed.push_back(mk_req(3, 16, 'h8001, 'h0000, 'h0000));
    directed.push_back(mk_req(3, 16, 'h8001, 'h0000, 'h0000));
    directed.push_back(mk_req(3, 16, 'h8001, 'h0000, 'h0000));
    directed.push_back(mk_req(4, 16, 'hFFFF, 'h5555, 'hAAAA)); // masks cancel out

    total       = directed.size() + RANDOM_ITEMS;
    phase_a_end = directed.size() + RANDOM_ITEMS / 3;
    phase_b_end = directed.size() + (2 * RANDOM_ITEMS) / 3;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Idle mix changes right after a rising edge, away from the falling-edge
    // drivers: sender light / receiver heavy, then swapped, then none.
    for (int unsigned k = 0; k < total; k++) begin
      if (k < phase_a_end) begin
        snd_idle_pct = 6;
        rsp_idle_pct = 54;
      end else if (k < phase_b_end) begin
        snd_idle_pct = 54;
        rsp_idle_pct = 6;
      end else begin
        snd_idle_pct = 0;
        rsp_idle_pct = 0;
      end
      if (k < directed.size()) send_request(directed[k]);
      else                     send_request(random_request());
    end
    @(negedge clk_i);
    req_if.valid <= 1'b0;

    // Drain, then give a stray late response time to show up
    while (picks.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (picks.pending() != 0)
      picks.report($sformatf("%0d responses never arrived", picks.pending()));

    if (picks.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/errp_pkg.sv
rtl/core/errp_if.sv
rtl/core/eligible_round_robin_picker_core.sv
tb/tb_eligible_round_robin_picker_core.sv
